// ===== rtl/core/sliding_window_receive_filter_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SLIDING_WINDOW_RECEIVE_FILTER_MACROS_SVH
`define SLIDING_WINDOW_RECEIVE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SWRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SWRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/swrf_pkg.sv =====
`timescale 1ns / 1ps

package swrf_pkg;

  localparam int unsigned SeqW     = 32;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_ACCEPTED  = 3'd0,
    VERDICT_BAD_FRAME = 3'd1,
    VERDICT_OUT_RANGE = 3'd2,
    VERDICT_DUPLICATE = 3'd3,
    VERDICT_STARTED   = 3'd4,
    VERDICT_CLOSED    = 3'd5
  } verdict_e;

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_PACKET = 1'b1
  } command_e;

  typedef enum logic {
    REG_DATA_TYPE = 1'b0,
    REG_CMD_TYPE  = 1'b1
  } reg_idx_e;

  typedef logic [TypeW-1:0] type_code_t;

endpackage

// ===== rtl/core/sliding_window_receive_filter.sv =====
`timescale 1ns / 1ps
// Sliding-window receive filter.
// Input stream: one item per packet header or window start. tuser selects
// start (0) or packet (1); tdata carries sequence number, frame-ok flag and
// type byte; tlast carries the header's last-packet mark.
// Output stream: one result item per input item. tuser is the verdict
// (accepted, bad frame/type, out of range, duplicate, started, closed);
// tdata carries slot and received count; tlast is high when the item
// closed the window.
// Output valid rises in the cycle after input accept. An item can be
// taken every cycle: the window check is a subtract, a compare and one
// bitmap lookup, and all state updates in the same cycle as the accept.
// The result register frees up when the receiver takes it, so the input
// stays ready under back-to-back traffic; when the receiver stalls the
// result holds and the input is stalled with it.
// Reset clears the window state, marks the window closed (packets get
// the closed verdict until the first start) and zeroes both type-code
// registers. The APB port holds the data and command type codes at 0x0
// and 0x4; writes are expected only while the stream is idle.
module sliding_window_receive_filter #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: [31:0] seq_num, [32] frame_ok, [40:33] type_code, rest zero
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [swrf_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: [0] command
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [2:0] slot, [6:3] received_count, [7] zero
  output logic [swrf_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: [2:0] verdict
  output logic [swrf_pkg::VerdictW-1:0]  m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swrf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [swrf_pkg::ApbDataW-1:0]  pwdata,
  output logic [swrf_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int unsigned OffW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);

  // configuration registers
  swrf_pkg::type_code_t data_type_q, cmd_type_q;
  swrf_pkg::reg_idx_e   reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = swrf_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= '0;
      cmd_type_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        swrf_pkg::REG_DATA_TYPE: data_type_q <= pwdata[swrf_pkg::TypeW-1:0];
        swrf_pkg::REG_CMD_TYPE:  cmd_type_q  <= pwdata[swrf_pkg::TypeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swrf_pkg::REG_DATA_TYPE: prdata = swrf_pkg::ApbDataW'(data_type_q);
      swrf_pkg::REG_CMD_TYPE:  prdata = swrf_pkg::ApbDataW'(cmd_type_q);
      default:                 prdata = '0;
    endcase
  end

  // window state
  logic [swrf_pkg::SeqW-1:0] base_q, base_d;
  logic [WINDOW-1:0]         map_q, map_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [OffW-1:0]           high_q, high_d;
  logic                      high_last_q, high_last_d;
  logic                      closed_q, closed_d;

  // result register
  logic                      out_valid_q;
  swrf_pkg::verdict_e        verdict_q, verdict_d;
  logic [swrf_pkg::SlotW-1:0]  slot_q, slot_d;
  logic [swrf_pkg::CountW-1:0] rcount_q, rcount_d;
  logic                      done_q, done_d;

  logic                      in_acc;
  logic [swrf_pkg::SeqW-1:0] seq;
  logic                      frame_ok;
  swrf_pkg::type_code_t      type_code;
  swrf_pkg::command_e        cmd;
  logic [swrf_pkg::SeqW:0]   diff;
  logic                      in_range;
  logic [OffW-1:0]           off;
  logic [CntW-1:0]           count_inc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign seq       = s_axis_tdata[swrf_pkg::SeqW-1:0];
  assign frame_ok  = s_axis_tdata[swrf_pkg::SeqW];
  assign type_code = s_axis_tdata[swrf_pkg::SeqW+swrf_pkg::TypeW:swrf_pkg::SeqW+1];
  assign cmd       = swrf_pkg::command_e'(s_axis_tuser);

  // range test without wrap: base <= seq <= base + WINDOW - 1
  assign diff      = {1'b0, seq} - {1'b0, base_q};
  assign in_range  = !diff[swrf_pkg::SeqW] &&
                     (diff[swrf_pkg::SeqW-1:0] <= swrf_pkg::SeqW'(WINDOW - 1));
  assign off       = diff[OffW-1:0];
  assign count_inc = count_q + CntW'(1);

  always_comb begin
    base_d      = base_q;
    map_d       = map_q;
    count_d     = count_q;
    high_d      = high_q;
    high_last_d = high_last_q;
    closed_d    = closed_q;
    verdict_d   = swrf_pkg::VERDICT_ACCEPTED;
    slot_d      = '0;
    done_d      = 1'b0;

    if (cmd == swrf_pkg::CMD_START) begin
      base_d      = seq;
      map_d       = '0;
      count_d     = '0;
      high_d      = '0;
      high_last_d = 1'b0;
      closed_d    = 1'b0;
      verdict_d   = swrf_pkg::VERDICT_STARTED;
    end else if (closed_q) begin
      verdict_d = swrf_pkg::VERDICT_CLOSED;
    end else if (!frame_ok || (type_code != data_type_q && type_code != cmd_type_q)) begin
      verdict_d = swrf_pkg::VERDICT_BAD_FRAME;
    end else if (!in_range) begin
      verdict_d = swrf_pkg::VERDICT_OUT_RANGE;
    end else if (map_q[off]) begin
      verdict_d = swrf_pkg::VERDICT_DUPLICATE;
    end else begin
      if (count_q == '0 || off > high_q) begin
        high_d      = off;
        high_last_d = s_axis_tlast;
      end
      map_d[off] = 1'b1;
      count_d    = count_inc;
      // complete up to a last-marked highest packet, or the window is full
      done_d     = (high_last_d && (CntW'(high_d) + CntW'(1) == count_inc)) ||
                   (count_inc == CntW'(WINDOW));
      closed_d   = done_d;
      slot_d     = swrf_pkg::SlotW'(off);
    end
    rcount_d = swrf_pkg::CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      map_q       <= '0;
      count_q     <= '0;
      high_q      <= '0;
      high_last_q <= 1'b0;
      closed_q    <= 1'b1;
    end else if (in_acc) begin
      base_q      <= base_d;
      map_q       <= map_d;
      count_q     <= count_d;
      high_q      <= high_d;
      high_last_q <= high_last_d;
      closed_q    <= closed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      verdict_q <= verdict_d;
      slot_q    <= slot_d;
      rcount_q  <= rcount_d;
      done_q    <= done_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = verdict_q;
  assign m_axis_tdata  = {1'b0, rcount_q, slot_q};
  assign m_axis_tlast  = done_q;

endmodule

// ===== rtl/core/swrf_checker.sv =====
`timescale 1ns / 1ps
`include "sliding_window_receive_filter_macros.svh"

module swrf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [swrf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [swrf_pkg::VerdictW-1:0] m_axis_tuser,
  input logic                          m_axis_tlast
);

  // every accepted item shows up as a result in the next cycle
  `SWRF_ASSERT_NXT(a_result_follows, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted item produced no result")

  // only an accepted packet can close the window
  `SWRF_ASSERT_IMP(a_close_on_accept, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tlast, m_axis_tuser == swrf_pkg::VERDICT_ACCEPTED,
    "window closed by a non-accepted item")

  // non-accepted items carry no slot
  `SWRF_ASSERT_IMP(a_slot_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != swrf_pkg::VERDICT_ACCEPTED),
    (m_axis_tdata[2:0] == 3'd0) && !m_axis_tlast, "slot or close on rejected item")

  // a fresh window starts empty
  `SWRF_ASSERT_IMP(a_start_empty, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == swrf_pkg::VERDICT_STARTED),
    m_axis_tdata[6:3] == 4'd0, "start result with nonzero count")

  `SWRF_ASSERT_NXT(a_hold_stalled, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "stalled result changed")

endmodule

bind sliding_window_receive_filter swrf_checker u_swrf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
